>>> hw/rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

    localparam int VALUE_W = 32;
    localparam int ACTION_W = 3;
    localparam int COUNT_W = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_LEFT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_RIGHT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_LEFT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_RIGHT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

    // Value shown at an end of an empty queue.
    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } t_state;

    typedef struct packed {
        logic exec;
        logic read;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/dq_if.sv
// Valid/ready channel interfaces for queue requests and results.
interface dq_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic signed [31:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface dq_out_if;
    logic                valid;
    logic                ready;
    logic                ok;
    logic signed [31:0]  left_value;
    logic signed [31:0]  right_value;
    logic [4:0]          count;

    modport source (output valid, output ok, output left_value, output right_value,
                    output count, input ready);
    modport sink (input valid, input ok, input left_value, input right_value,
                  input count, output ready);
endinterface

>>> hw/rtl/double_ended_queue.sv
// Each accepted item passes the read and response states before its result is loaded into
//   the output register (later if the output stalls); no new item is taken before that load.
//   End pointers updated and push written on accept; both ends then read via registered ports.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) empties the queue: pointers, count, sequencer and
//   output valid clear at once; the entry memory is not cleared and needs no pass.
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dq_in_if.sink     i_in,
    dq_out_if.source  o_out
);

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The sequencer owns the request handshake: it takes one item in idle,
    // advances through the memory read, then loads the result register.
    dq_ctrl u_dq_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the ring pointers, the entry count, the entry memory
    // and the output register that drives the result channel.
    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dq_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_action      (i_in.action),
        .i_value       (i_in.value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_ok          (o_out.ok),
        .o_left_value  (o_out.left_value),
        .o_right_value (o_out.right_value),
        .o_count       (o_out.count)
    );

endmodule

>>> hw/rtl/dq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hw/rtl/dq_ctrl.sv
// Sequencer for the queue: accept, read ends, load result.
module dq_ctrl import dq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                // hold until the result register can take the new item
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/dq_dp.sv
// Queue datapath: end pointers, count, entry memory and result register.
module dq_dp import dq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_ok,
    output logic signed [VALUE_W-1:0]  o_left_value,
    output logic signed [VALUE_W-1:0]  o_right_value,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [PW-1:0] r_left, n_left;
    logic [PW-1:0] r_right, n_right;
    logic [CW-1:0] r_count, n_count;
    logic          r_ok, n_ok;

    logic                      r_out_valid;
    logic                      r_out_ok;
    logic signed [VALUE_W-1:0] r_out_left;
    logic signed [VALUE_W-1:0] r_out_right;
    logic [COUNT_W-1:0]        r_out_count;

    logic [PW-1:0] left_prev, left_next, right_prev, right_next;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [VALUE_W-1:0] rd_left, rd_right;
    logic [CW+COUNT_W-1:0] count_ext;

    // ring neighbors, valid for any depth
    assign left_prev  = (r_left == '0) ? PTR_LAST : r_left - 1'b1;
    assign left_next  = (r_left == PTR_LAST) ? '0 : r_left + 1'b1;
    assign right_prev = (r_right == '0) ? PTR_LAST : r_right - 1'b1;
    assign right_next = (r_right == PTR_LAST) ? '0 : r_right + 1'b1;

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_count = r_count;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_left;
        case (i_action)
            ACT_PUSH_LEFT, ACT_PUSH_RIGHT: begin
                if (r_count != CNT_FULL) begin
                    n_ok    = 1'b1;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_right = r_left;
                        wr_addr = r_left;
                    end else if (i_action == ACT_PUSH_LEFT) begin
                        n_left  = left_prev;
                        wr_addr = left_prev;
                    end else begin
                        n_right = right_next;
                        wr_addr = right_next;
                    end
                end
            end
            ACT_POP_LEFT, ACT_POP_RIGHT: begin
                if (r_count != '0) begin
                    n_ok    = 1'b1;
                    n_count = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_right = r_left;
                    end else if (i_action == ACT_POP_LEFT) begin
                        n_left = left_next;
                    end else begin
                        n_right = right_prev;
                    end
                end
            end
            ACT_CLEAR: begin
                if (r_count != '0) begin
                    n_ok    = 1'b1;
                    n_count = '0;
                    n_left  = '0;
                    n_right = '0;
                end
            end
            default: begin
            end
        endcase
    end

    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_dq_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.exec & wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (i_value),
        .i_re      (i_cmd.read),
        .i_raddr_a (r_left),
        .i_raddr_b (r_right),
        .o_rdata_a (rd_left),
        .o_rdata_b (rd_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_ok    <= r_ok;
            r_out_left  <= (r_count == '0) ? EMPTY_VALUE : rd_left;
            r_out_right <= (r_count == '0) ? EMPTY_VALUE : rd_right;
            r_out_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_out_ok;
    assign o_left_value      = r_out_left;
    assign o_right_value     = r_out_right;
    assign o_count           = r_out_count;

endmodule

>>> hw/rtl/dq_checker.sv
// Port-level checks on the double-ended queue, bound to the top level.
module dq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic         i_out_ok,
    input logic [31:0]  i_out_left,
    input logic [31:0]  i_out_right,
    input logic [4:0]   i_out_count
);

    // an empty queue shows -1 at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_count == 5'd0) |->
        (i_out_left == 32'hFFFF_FFFF && i_out_right == 32'hFFFF_FFFF))
        else $error("empty result shows a stored value");

    // one item in flight: no request taken right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while previous item still in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_ok) && $stable(i_out_left) &&
         $stable(i_out_right) && $stable(i_out_count)))
        else $error("stalled result changed");

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ok    (o_out.ok),
    .i_out_left  (o_out.left_value),
    .i_out_right (o_out.right_value),
    .i_out_count (o_out.count)
);

>>> tb/sv/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random items, ordered check.
module tb_double_ended_queue import dq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DQ_DEPTH    = 16;
    localparam int GAP_MAX     = 15;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    // Action codes the block does not define; they must do nothing and report failure.
    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    // One request as queued for the driver: payload, idle cycles before it, and
    // whether the sender must wait for every outstanding result before it.
    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        int                        gap;
        bit                        drain;
    } t_dq_request;

    // What the block should report after one step: flag, both ends, occupancy.
    typedef struct {
        logic                      ok;
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;
        logic [COUNT_W-1:0]        count;
    } t_dq_view;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_in_if  in_if ();
    dq_out_if out_if ();

    double_ended_queue #(
        .DEPTH (DQ_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the queue contents, kept in step with every accepted item.
    logic signed [VALUE_W-1:0] ring [DQ_DEPTH];
    int left_idx  = 0;
    int right_idx = 0;
    int fill      = 0;

    t_dq_request request_backlog[$];
    t_dq_view    awaited_views[$];

    int hold_cnt   = 0;
    int stall_left = 0;
    int cycle_cnt  = 0;

    int n_sent        = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int n_push_ok     = 0;
    int n_pop_ok      = 0;
    int n_clear_ok    = 0;
    int n_full_reject = 0;
    int n_empty_fail  = 0;
    int peak_fill     = 0;

    // Apply one operation to the mirrored deque and return the view of both ends after it.
    function automatic t_dq_view deque_step(input logic [ACTION_W-1:0] action,
                                            input logic signed [VALUE_W-1:0] value);
        t_dq_view view;
        view.ok = 1'b0;
        case (action)
            ACT_PUSH_LEFT, ACT_PUSH_RIGHT: begin
                if (fill < DQ_DEPTH) begin
                    // Onto an empty queue both ends land on the left slot.
                    if (fill == 0)
                        right_idx = left_idx;
                    else if (action == ACT_PUSH_LEFT)
                        left_idx = (left_idx + DQ_DEPTH - 1) % DQ_DEPTH;
                    else
                        right_idx = (right_idx + 1) % DQ_DEPTH;
                    ring[(action == ACT_PUSH_LEFT) ? left_idx : right_idx] = value;
                    fill++;
                    view.ok = 1'b1;
                    n_push_ok++;
                end else begin
                    n_full_reject++;
                end
            end
            ACT_POP_LEFT, ACT_POP_RIGHT: begin
                if (fill != 0) begin
                    fill--;
                    // Popping the last entry collapses the right end onto the left.
                    if (fill == 0)
                        right_idx = left_idx;
                    else if (action == ACT_POP_LEFT)
                        left_idx = (left_idx + 1) % DQ_DEPTH;
                    else
                        right_idx = (right_idx + DQ_DEPTH - 1) % DQ_DEPTH;
                    view.ok = 1'b1;
                    n_pop_ok++;
                end else begin
                    n_empty_fail++;
                end
            end
            ACT_CLEAR: begin
                if (fill != 0) begin
                    fill      = 0;
                    left_idx  = 0;
                    right_idx = 0;
                    view.ok   = 1'b1;
                    n_clear_ok++;
                end else begin
                    n_empty_fail++;
                end
            end
            default: ;
        endcase
        if (fill > peak_fill)
            peak_fill = fill;
        if (fill == 0) begin
            view.left_value  = EMPTY_VALUE;
            view.right_value = EMPTY_VALUE;
        end else begin
            view.left_value  = ring[left_idx];
            view.right_value = ring[right_idx];
        end
        view.count = fill[COUNT_W-1:0];
        return view;
    endfunction

    // Driver: record the prediction for each accepted item, then present the next
    // one from the backlog once its idle gap has passed.
    always @(posedge i_clk) begin : drive_requests
        t_dq_request head;
        logic        next_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            hold_cnt = 0;
        end else begin
            next_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                awaited_views.push_back(deque_step(in_if.action, in_if.value));
                n_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && request_backlog.size() != 0) begin
                head = request_backlog[0];
                if (hold_cnt < head.gap) begin
                    hold_cnt++;
                end else if (!head.drain || awaited_views.size() == 0) begin
                    // Hold a draining item until every outstanding result is back.
                    void'(request_backlog.pop_front());
                    in_if.action <= head.action;
                    in_if.value  <= head.value;
                    next_valid = 1'b1;
                    hold_cnt   = 0;
                end
            end
            // Drive valid once per edge so a back-to-back item never drops it.
            in_if.valid <= next_valid;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then
    // stall the output for a random number of cycles.
    always @(posedge i_clk) begin : check_results
        t_dq_view want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (awaited_views.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    n_errors++;
                end else begin
                    want = awaited_views.pop_front();
                    if (out_if.ok !== want.ok) begin
                        $error("ok mismatch: expected %0d, got %0d", want.ok, out_if.ok);
                        n_errors++;
                    end
                    if (out_if.left_value !== want.left_value) begin
                        $error("left_value mismatch: expected %0d, got %0d",
                               want.left_value, out_if.left_value);
                        n_errors++;
                    end
                    if (out_if.right_value !== want.right_value) begin
                        $error("right_value mismatch: expected %0d, got %0d",
                               want.right_value, out_if.right_value);
                        n_errors++;
                    end
                    if (out_if.count !== want.count) begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, out_if.count);
                        n_errors++;
                    end
                    n_checked++;
                end
                // Every third block of 40 results runs with the output never stalled.
                stall_left = ((n_checked / 40) % 3 == 1) ? 0 : $urandom_range(0, GAP_MAX);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_if.ready <= (stall_left == 0);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles with %0d results outstanding",
                   cycle_cnt, awaited_views.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_request(input logic [ACTION_W-1:0] action,
                               input logic signed [VALUE_W-1:0] value,
                               input int gap, input bit drain);
        t_dq_request req;
        req.action = action;
        req.value  = value;
        req.gap    = gap;
        req.drain  = drain;
        request_backlog.push_back(req);
    endtask

    initial begin : stimulus
        int                        push_pct;
        int                        roll;
        int                        n_items;
        bit                        quiet;
        bit                        allow_clear;
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;

        // Known values on every block input from time zero.
        in_if.valid  = 1'b0;
        in_if.action = ACT_PUSH_LEFT;
        in_if.value  = '0;
        out_if.ready = 1'b0;

        // Directed: failures on empty, pushes of the extremes, spare codes,
        // pops from both ends down to empty, clear with and without entries.
        add_request(ACT_POP_LEFT,    32'sd0,     0, 1'b0);
        add_request(ACT_POP_RIGHT,   32'sd0,     0, 1'b0);
        add_request(ACT_CLEAR,       32'sd0,     2, 1'b0);
        add_request(ACT_PUSH_RIGHT,  VALUE_MAX,  0, 1'b0);
        add_request(ACT_POP_LEFT,    32'sd0,     0, 1'b0);
        add_request(ACT_PUSH_LEFT,   VALUE_MIN,  1, 1'b0);
        add_request(ACT_PUSH_RIGHT,  32'sd0,     0, 1'b0);
        add_request(ACT_PUSH_LEFT,   -32'sd1,    0, 1'b0);
        add_request(ACT_PUSH_RIGHT,  VALUE_MAX,  3, 1'b0);
        add_request(ACT_SPARE_FIRST, VALUE_MIN,  0, 1'b0);
        add_request(ACT_SPARE_MID,   VALUE_MAX,  0, 1'b0);
        add_request(ACT_SPARE_LAST,  -32'sd1,    0, 1'b0);
        add_request(ACT_POP_RIGHT,   32'sd0,     0, 1'b0);
        add_request(ACT_POP_LEFT,    32'sd0,     5, 1'b0);
        add_request(ACT_CLEAR,       32'sd0,     0, 1'b0);
        add_request(ACT_PUSH_LEFT,   32'sd12345, 0, 1'b0);
        add_request(ACT_POP_RIGHT,   32'sd0,     0, 1'b0);
        add_request(ACT_POP_RIGHT,   32'sd0,     0, 1'b0);
        add_request(ACT_CLEAR,       32'sd0,     0, 1'b0);

        // Random: segments of 20 items lean toward pushing, popping or neither,
        // so the queue swings between empty and full and wraps the ring.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                roll        = $urandom_range(0, 2);
                push_pct    = (roll == 0) ? 90 : (roll == 1) ? 15 : 50;
                allow_clear = (roll != 0);
                quiet       = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            else if (roll < 6 && allow_clear)
                action = ACT_CLEAR;
            else if ($urandom_range(0, 99) < push_pct)
                action = $urandom_range(0, 1) ? ACT_PUSH_RIGHT : ACT_PUSH_LEFT;
            else
                action = $urandom_range(0, 1) ? ACT_POP_RIGHT : ACT_POP_LEFT;
            case ($urandom_range(0, 9))
                0:       value = VALUE_MIN;
                1:       value = VALUE_MAX;
                2:       value = 32'sd0;
                3:       value = -32'sd1;
                default: value = $urandom;
            endcase
            // Drain once right after the directed part, then now and then at random.
            add_request(action, value, quiet ? 0 : $urandom_range(0, GAP_MAX),
                        (i == 0) || ($urandom_range(0, 49) == 0));
        end
        n_items = request_backlog.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every queued item has its result checked, then idle.
        while (n_checked < n_items)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_views.size() != 0) begin
            $error("%0d results never arrived", awaited_views.size());
            n_errors++;
        end
        $display("Sent %0d items, checked %0d results, peak occupancy %0d of %0d.",
                 n_sent, n_checked, peak_fill, DQ_DEPTH);
        $display("Pushes %0d, pops %0d, clears %0d, full rejects %0d, empty failures %0d.",
                 n_push_ok, n_pop_ok, n_clear_ok, n_full_reject, n_empty_fail);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
